>>> hw/rtl/tsem_pkg.sv
// types and codes shared by the timeline semaphore table
package tsem_pkg;

   localparam int ValueWidth = 64;
   // table size and queue depth are fixed here; both are powers of two
   localparam int NumSems = 16;
   localparam int WaitDepth = 8;
   localparam int HandleWidth = $clog2(NumSems);
   localparam int QueueWidth = $clog2(WaitDepth);
   localparam int CountWidth = $clog2(WaitDepth + 1);
   localparam int NextWidth = $clog2(NumSems + 1);
   localparam int WaiterDepth = NumSems * WaitDepth;
   localparam int WaiterAddrWidth = HandleWidth + QueueWidth;

   typedef enum logic [2:0] {
      ACT_CREATE  = 3'd0,
      ACT_SIGNAL  = 3'd1,
      ACT_WAIT    = 3'd2,
      ACT_QUERY   = 3'd3,
      ACT_DESTROY = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]             action;
      logic [HandleWidth-1:0] handle;
      logic [ValueWidth-1:0]  value;
      logic [ValueWidth-1:0]  tag;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HandleWidth-1:0] handle_out;
      logic [ValueWidth-1:0]  read_value;
      logic                   wake_valid;
      logic [ValueWidth-1:0]  wake_data;
      logic                   last;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_POP_READ,
      S_POP_CHECK
   } state_type;

endpackage

>>> hw/rtl/timeline_semaphore_table_unit.sv
// timeline semaphore table: top level with per-slot state, control sequencer and waiter store
//
// usage: commands arrive on the req_ channel (create, signal, wait, query, destroy);
// results leave on the rsp_ channel, one item per command, or one item per released
// waiter for a signal or destroy that releases any, with last set on the final one.
// each channel moves an item when valid is high and stall is low.
// one command is in flight at a time; req_stall is high from acceptance until the
// sequencer is idle again, and during reset.
// a command that needs no waiter read is settled in S_DECIDE, which registers its item
// in the output register and returns to S_IDLE. a valid signal or destroy reads the
// waiter memory through S_POP_READ and S_POP_CHECK, k+1 reads for k released waiters;
// each wake is held until the next check tells whether it is the final one, and with
// k = 0 a single item goes out after the one read.
// waiter entries live in a synchronous memory of NumSems*WaitDepth entries; slot
// values, flags and queue pointers are flip-flops.
// reset clears all slot flags, pointers, values and the handle counter at once;
// waiter entries are written before they are ever read and need no clearing.
// when the receiver stalls, the item stays in the output register and the
// sequencer holds until it is taken.
module timeline_semaphore_table_unit
   import tsem_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [ValueWidth-1:0] sem_value_ff [NumSems];
   logic [NumSems-1:0]    alloc_ff, dead_ff;
   logic [QueueWidth-1:0] head_ff [NumSems];
   logic [CountWidth-1:0] count_ff [NumSems];
   logic [NextWidth-1:0]  next_free_ff;

   state_type             state_ff, state_in;
   req_type               cmd_ff;
   rsp_type               out_ff;
   logic                  out_valid_ff;
   logic                  pend_ff;
   logic [ValueWidth-1:0] pend_tag_ff;

   // current slot fields
   logic [HandleWidth-1:0]     slot;
   logic                       live;
   logic [ValueWidth-1:0]      cur_val;
   logic [QueueWidth-1:0]      cur_head;
   logic [CountWidth-1:0]      cur_count;
   logic [ValueWidth-1:0]      rd_expected, rd_tag;
   logic                       wr_en;
   logic [WaiterAddrWidth-1:0] wr_addr, rd_addr;
   logic [QueueWidth-1:0]      tail;
   logic [QueueWidth-1:0]      head_inc;
   logic                       full_q, pop_ok, grow, out_free;
   rsp_type                    res;
   logic                       res_en;

   assign slot      = cmd_ff.handle;
   assign live      = alloc_ff[slot] && !dead_ff[slot];
   assign cur_val   = sem_value_ff[slot];
   assign cur_head  = head_ff[slot];
   assign cur_count = count_ff[slot];
   assign full_q    = (cur_count == CountWidth'(WaitDepth));
   assign grow      = (cmd_ff.value > cur_val);
   assign tail      = cur_head + cur_count[QueueWidth-1:0];
   assign head_inc  = cur_head + QueueWidth'(1);
   assign rd_addr   = {slot, cur_head};
   assign wr_addr   = {slot, tail};
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // head waiter may leave: destroy drains all, signal checks expected value
   assign pop_ok = (cur_count != '0) &&
      ((cmd_ff.action == ACT_DESTROY) || (cmd_ff.value >= rd_expected));

   assign wr_en = (state_ff == S_DECIDE) && out_free && (cmd_ff.action == ACT_WAIT) &&
      live && !(cur_val >= cmd_ff.value) && !full_q;

   tsem_waiter_ram u_ram (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_expected (cmd_ff.value),
      .wr_tag      (cmd_ff.tag),
      .rd_addr     (rd_addr),
      .rd_expected (rd_expected),
      .rd_tag      (rd_tag)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_DECIDE;
         S_DECIDE: begin
            if (out_free) begin
               if (live && cmd_ff.action == ACT_DESTROY) state_in = S_POP_READ;
               else if (live && cmd_ff.action == ACT_SIGNAL && grow) state_in = S_POP_READ;
               else state_in = S_IDLE;
            end
         end
         S_POP_READ:  state_in = S_POP_CHECK;
         S_POP_CHECK: begin
            if (out_free) begin
               if (pop_ok) state_in = S_POP_READ;
               else state_in = S_IDLE;
            end
         end
      endcase
   end

   // item formed at a decision point
   always_comb begin
      res = '0;
      res.last = 1'b1;
      res_en = 1'b0;
      if (state_ff == S_DECIDE && out_free) begin
         unique case (cmd_ff.action)
            ACT_CREATE: begin
               res_en = 1'b1;
               if (next_free_ff >= NextWidth'(NumSems)) res.status = ST_FULL;
               else res.handle_out = next_free_ff[HandleWidth-1:0];
            end
            ACT_SIGNAL: begin
               if (!live || !grow) begin
                  res_en = 1'b1;
                  res.status = ST_INVALID;
               end
            end
            ACT_WAIT: begin
               res_en = 1'b1;
               if (!live) res.status = ST_INVALID;
               else if (cur_val >= cmd_ff.value) begin
                  res.wake_valid = 1'b1;
                  res.wake_data = cmd_ff.tag;
               end else if (full_q) res.status = ST_FULL;
            end
            ACT_QUERY: begin
               res_en = 1'b1;
               if (!live) begin
                  res.status = ST_INVALID;
                  res.read_value = '1;
               end else res.read_value = cur_val;
            end
            ACT_DESTROY: begin
               if (!live) begin
                  res_en = 1'b1;
                  res.status = ST_INVALID;
               end
            end
            default: begin
               res_en = 1'b1;
               res.status = ST_INVALID;
            end
         endcase
      end else if (state_ff == S_POP_CHECK && out_free) begin
         // a held wake goes out once the next check tells whether it is final
         if (pend_ff) begin
            res_en = 1'b1;
            res.wake_valid = 1'b1;
            res.wake_data = pend_tag_ff;
            res.last = !pop_ok;
         end else if (!pop_ok) begin
            res_en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (res_en) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
         if (state_ff == S_POP_CHECK && out_free) pend_ff <= pop_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) cmd_ff <= req_data;
      if (res_en) out_ff <= res;
      if (state_ff == S_POP_CHECK && out_free && pop_ok) pend_tag_ff <= rd_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= '0;
         alloc_ff <= '0;
         dead_ff <= '0;
         for (int i = 0; i < NumSems; i++) begin
            sem_value_ff[i] <= '0;
            head_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (state_ff == S_DECIDE && out_free) begin
            if (cmd_ff.action == ACT_CREATE && next_free_ff < NextWidth'(NumSems)) begin
               sem_value_ff[next_free_ff[HandleWidth-1:0]] <= cmd_ff.value;
               alloc_ff[next_free_ff[HandleWidth-1:0]] <= 1'b1;
               dead_ff[next_free_ff[HandleWidth-1:0]] <= 1'b0;
               head_ff[next_free_ff[HandleWidth-1:0]] <= '0;
               count_ff[next_free_ff[HandleWidth-1:0]] <= '0;
               next_free_ff <= next_free_ff + NextWidth'(1);
            end
            if (live && cmd_ff.action == ACT_SIGNAL && grow)
               sem_value_ff[slot] <= cmd_ff.value;
            if (live && cmd_ff.action == ACT_DESTROY) dead_ff[slot] <= 1'b1;
            if (wr_en) count_ff[slot] <= cur_count + CountWidth'(1);
         end
         if (state_ff == S_POP_CHECK && out_free && pop_ok) begin
            head_ff[slot] <= head_inc;
            count_ff[slot] <= cur_count - CountWidth'(1);
         end
      end
   end

endmodule

>>> hw/rtl/tsem_waiter_ram.sv
// waiter store: expected value and tag per queue entry, one write and one read port
module tsem_waiter_ram
   import tsem_pkg::*;
(
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [WaiterAddrWidth-1:0] wr_addr,
   input  logic [ValueWidth-1:0]      wr_expected,
   input  logic [ValueWidth-1:0]      wr_tag,
   input  logic [WaiterAddrWidth-1:0] rd_addr,
   output logic [ValueWidth-1:0]      rd_expected,
   output logic [ValueWidth-1:0]      rd_tag
);

   logic [2*ValueWidth-1:0] mem [WaiterDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_expected, wr_tag};
      end
      {rd_expected, rd_tag} <= mem[rd_addr];
   end

endmodule

>>> tb/tb_timeline_semaphore_table_unit.sv
// testbench for the timeline semaphore table: directed table, random commands, checked by a predictor
module tb_timeline_semaphore_table_unit;
   import tsem_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 20000;
   localparam logic [63:0] AllOnes = '1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   timeline_semaphore_table_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [63:0] sem_val [NumSems];
   logic        sem_alloc [NumSems];
   logic        sem_dead [NumSems];
   int          next_handle;
   logic [63:0] wait_exp [NumSems][WaitDepth];
   logic [63:0] wait_tag [NumSems][WaitDepth];
   int          q_head [NumSems];
   int          q_count [NumSems];

   rsp_type expected_rsps[$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_cycles = 0;
   int      idle_count = 0;

   function automatic rsp_type mk_rsp(logic [1:0] st, logic [3:0] h, logic [63:0] rv,
                                      logic wv, logic [63:0] wd);
      rsp_type r;
      r.status = st;
      r.handle_out = h;
      r.read_value = rv;
      r.wake_valid = wv;
      r.wake_data = wd;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic bit is_live(int h);
      return sem_alloc[h] && !sem_dead[h];
   endfunction

   task automatic pop_waiter(int s);
      rsp_type r;
      r = mk_rsp(ST_OK, '0, '0, 1'b1, wait_tag[s][q_head[s]]);
      r.last = 1'b0;
      expected_rsps.push_back(r);
      q_head[s] = (q_head[s] + 1) % WaitDepth;
      q_count[s]--;
   endtask

   // applies one command to the predictor and queues its results
   task automatic predict_command(req_type c);
      int s;
      int n;
      int tail;
      s = c.handle;
      n = 0;
      unique case (c.action)
         ACT_CREATE: begin
            if (next_handle >= NumSems) begin
               expected_rsps.push_back(mk_rsp(ST_FULL, '0, '0, 1'b0, '0));
            end else begin
               s = next_handle++;
               sem_val[s] = c.value;
               sem_alloc[s] = 1'b1;
               sem_dead[s] = 1'b0;
               q_head[s] = 0;
               q_count[s] = 0;
               expected_rsps.push_back(mk_rsp(ST_OK, 4'(s), '0, 1'b0, '0));
            end
         end
         ACT_SIGNAL: begin
            if (!is_live(s) || c.value <= sem_val[s]) begin
               expected_rsps.push_back(mk_rsp(ST_INVALID, '0, '0, 1'b0, '0));
            end else begin
               sem_val[s] = c.value;
               while (q_count[s] > 0 && c.value >= wait_exp[s][q_head[s]]) begin
                  pop_waiter(s);
                  n++;
               end
               if (n == 0) expected_rsps.push_back(mk_rsp(ST_OK, '0, '0, 1'b0, '0));
               else expected_rsps[$].last = 1'b1;
            end
         end
         ACT_WAIT: begin
            if (!is_live(s)) begin
               expected_rsps.push_back(mk_rsp(ST_INVALID, '0, '0, 1'b0, '0));
            end else if (sem_val[s] >= c.value) begin
               expected_rsps.push_back(mk_rsp(ST_OK, '0, '0, 1'b1, c.tag));
            end else if (q_count[s] >= WaitDepth) begin
               expected_rsps.push_back(mk_rsp(ST_FULL, '0, '0, 1'b0, '0));
            end else begin
               tail = (q_head[s] + q_count[s]) % WaitDepth;
               wait_exp[s][tail] = c.value;
               wait_tag[s][tail] = c.tag;
               q_count[s]++;
               expected_rsps.push_back(mk_rsp(ST_OK, '0, '0, 1'b0, '0));
            end
         end
         ACT_QUERY: begin
            if (!is_live(s)) expected_rsps.push_back(mk_rsp(ST_INVALID, '0, AllOnes, 1'b0, '0));
            else expected_rsps.push_back(mk_rsp(ST_OK, '0, sem_val[s], 1'b0, '0));
         end
         ACT_DESTROY: begin
            if (!is_live(s)) begin
               expected_rsps.push_back(mk_rsp(ST_INVALID, '0, '0, 1'b0, '0));
            end else begin
               sem_dead[s] = 1'b1;
               while (q_count[s] > 0) begin
                  pop_waiter(s);
                  n++;
               end
               if (n == 0) expected_rsps.push_back(mk_rsp(ST_OK, '0, '0, 1'b0, '0));
               else expected_rsps[$].last = 1'b1;
            end
         end
         default: expected_rsps.push_back(mk_rsp(ST_INVALID, '0, '0, 1'b0, '0));
      endcase
   endtask

   task automatic reset_predictor();
      for (int i = 0; i < NumSems; i++) begin
         sem_val[i] = '0;
         sem_alloc[i] = 1'b0;
         sem_dead[i] = 1'b0;
         q_head[i] = 0;
         q_count[i] = 0;
      end
      next_handle = 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // drives one command, honoring the sender idle rate; valid stays up between items unless an idle is drawn
   task automatic send_command(req_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(c);
   endtask

   function automatic req_type mk_cmd(logic [2:0] a, logic [3:0] h, logic [63:0] v,
                                      logic [63:0] t);
      req_type c;
      c.action = a;
      c.handle = h;
      c.value = v;
      c.tag = t;
      return c;
   endfunction

   // random command biased toward created handles and queued waits that later get released
   function automatic req_type rand_command();
      int pick;
      int h;
      logic [63:0] v;
      pick = $urandom_range(99);
      h = (next_handle > 0 && $urandom_range(9) != 0) ?
          $urandom_range(next_handle - 1) : $urandom_range(15);
      v = sem_val[h];
      if (pick < 3) return mk_cmd(ACT_CREATE, 4'(h), rand64(), rand64());
      if (pick < 33) begin
         v = v + $urandom_range(40);
         if ($urandom_range(19) == 0) v = rand64();
         return mk_cmd(ACT_SIGNAL, 4'(h), v, rand64());
      end
      if (pick < 75) begin
         v = v + $urandom_range(60) - 10;
         if ($urandom_range(19) == 0) v = rand64();
         return mk_cmd(ACT_WAIT, 4'(h), v, rand64());
      end
      if (pick < 88) return mk_cmd(ACT_QUERY, 4'(h), rand64(), rand64());
      if (pick < 91) return mk_cmd(ACT_DESTROY, 4'(h), rand64(), rand64());
      if (pick < 93) return mk_cmd(3'($urandom_range(5, 7)), 4'(h), rand64(), rand64());
      return mk_cmd(ACT_QUERY, 4'($urandom_range(15)), rand64(), rand64());
   endfunction

   // receiver stall and long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result item %p", rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.handle_out !== want.handle_out) begin
               $error("handle_out: expected %0d actual %0d", want.handle_out,
                      rsp_data.handle_out);
               errors++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value: expected %h actual %h", want.read_value,
                      rsp_data.read_value);
               errors++;
            end
            if (rsp_data.wake_valid !== want.wake_valid) begin
               $error("wake_valid: expected %0d actual %0d", want.wake_valid,
                      rsp_data.wake_valid);
               errors++;
            end
            if (rsp_data.wake_data !== want.wake_data) begin
               $error("wake_data: expected %h actual %h", want.wake_data, rsp_data.wake_data);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d actual %0d", want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= IdleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   typedef struct {
      req_type     cmd;
      bit          typed;
      logic [1:0]  st;
      logic [3:0]  h;
      logic [63:0] rv;
   } directed_row_type;

   directed_row_type plan[$];

   task automatic add_row(logic [2:0] a, logic [3:0] h, logic [63:0] v, logic [63:0] t,
                          bit typed, logic [1:0] st, logic [3:0] ho, logic [63:0] rv);
      directed_row_type r;
      r.cmd = mk_cmd(a, h, v, t);
      r.typed = typed;
      r.st = st;
      r.h = ho;
      r.rv = rv;
      plan.push_back(r);
   endtask

   initial begin
      rsp_type typed_rsp;
      reset_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: typed results where obvious, others via predictor
      add_row(ACT_QUERY, 4'd0, '0, '0, 1, ST_INVALID, 4'd0, AllOnes);
      add_row(ACT_SIGNAL, 4'd15, 64'd5, '0, 1, ST_INVALID, 4'd0, '0);
      add_row(ACT_WAIT, 4'd3, 64'd5, '0, 1, ST_INVALID, 4'd0, '0);
      add_row(ACT_DESTROY, 4'd0, '0, '0, 1, ST_INVALID, 4'd0, '0);
      add_row(3'd7, 4'd0, AllOnes, AllOnes, 1, ST_INVALID, 4'd0, '0);
      add_row(ACT_CREATE, 4'd9, 64'd0, '0, 1, ST_OK, 4'd0, '0);
      add_row(ACT_CREATE, 4'd0, AllOnes - 1, AllOnes, 1, ST_OK, 4'd1, '0);
      add_row(ACT_QUERY, 4'd1, '0, '0, 1, ST_OK, 4'd0, AllOnes - 1);
      add_row(ACT_WAIT, 4'd0, 64'd0, AllOnes, 0, 0, 0, 0);
      for (int i = 0; i < 9; i++) add_row(ACT_WAIT, 4'd0, 64'(10 + i), 64'(100 + i), 0, 0, 0, 0);
      add_row(ACT_SIGNAL, 4'd0, 64'd0, '0, 1, ST_INVALID, 4'd0, '0);
      add_row(ACT_SIGNAL, 4'd0, 64'd13, '0, 0, 0, 0, 0);
      add_row(ACT_SIGNAL, 4'd1, AllOnes, '0, 0, 0, 0, 0);
      add_row(ACT_DESTROY, 4'd0, '0, '0, 0, 0, 0, 0);
      add_row(ACT_QUERY, 4'd0, '0, '0, 1, ST_INVALID, 4'd0, AllOnes);
      add_row(ACT_SIGNAL, 4'd1, AllOnes, '0, 1, ST_INVALID, 4'd0, '0);
      foreach (plan[i]) begin
         send_command(plan[i].cmd);
         if (plan[i].typed) begin
            typed_rsp = mk_rsp(plan[i].st, plan[i].h, plan[i].rv, 1'b0, '0);
            expected_rsps[$] = typed_rsp;
         end
      end

      // random phases with different idling mixes
      for (int phase = 0; phase < 5; phase++) begin
         unique case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            3: begin send_idle_pct = 30; recv_stall_pct = 30; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 4) hold_cycles = 300;
         for (int n = 0; n < 78; n++) send_command(rand_command());
      end
      // table exhaustion
      repeat (18) send_command(mk_cmd(ACT_CREATE, '0, rand64(), rand64()));
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
